/* hw/rtl/subnet_mask_match_counter_defines.svh */
// assertion macros shared by the subnet mask match counter rtl
`ifndef SUBNET_MASK_MATCH_COUNTER_DEFINES_SVH
`define SUBNET_MASK_MATCH_COUNTER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define SMMC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define SMMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/smmc_pkg.sv */
// shared constants and types of the subnet mask match counter
package smmc_pkg;

    // fixed field widths
    localparam int WORD_W = 32;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;

    // request action codes
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // scan engine status seen by the top level
    typedef struct packed {
        logic busy;
        logic result_valid;
    } t_scan_stat;

endpackage

/* hw/rtl/subnet_mask_match_counter.sv */
// top level of the subnet mask match counter
//
// Input channel (i_in_valid / o_in_ready) carries one request per handshake.
// A load request (i_action = 0) writes i_mask_value into table entry
// i_entry_index in the cycle it is accepted; an index at or above MAX_MASKS
// is dropped. Loads give no result.
// A query request (i_action = 1) counts the first N table entries under
// which i_first_address and i_second_address fall into the same subnet,
// N = min(mask_count, MAX_MASKS). The scan reads one mask per cycle from a
// single-port-read table ram. A query holds o_in_ready low until its result
// is handed to the output channel (o_out_valid / i_out_ready). Only written
// entries may be examined. The result sits in an output register; a new
// request is accepted as soon as the scan engine has handed its result over.
// If the receiver stalls with a result still held, a finished query waits in
// the engine and no new request is taken. mask_count is written through
// i_cfg_we / i_cfg_wdata, by the user only while the block is idle; the
// block does not enforce it. Synchronous reset clears mask_count and all
// control state; table contents are undefined until loaded.
`include "subnet_mask_match_counter_defines.svh"

module subnet_mask_match_counter #(
    parameter int MAX_MASKS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_action,
    input  logic [smmc_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [smmc_pkg::WORD_W-1:0] i_mask_value,
    input  logic [smmc_pkg::WORD_W-1:0] i_first_address,
    input  logic [smmc_pkg::WORD_W-1:0] i_second_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [smmc_pkg::CNT_W-1:0]  o_match_count,
    input  logic                        i_cfg_we,
    input  logic [smmc_pkg::CNT_W-1:0]  i_cfg_wdata
);
    import smmc_pkg::*;

    localparam int AW = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1;
    localparam int CW = $clog2(MAX_MASKS + 1);

    logic [CNT_W-1:0]      r_mask_count;
    logic                  r_out_valid;
    logic [CNT_W-1:0]      r_match;

    logic                  in_acc;
    logic                  idx_ok;
    logic                  ram_we;
    logic                  start;
    logic [AW+IDX_W-1:0]   idx_ext;
    logic [CW+CNT_W-1:0]   cnt_ext;
    logic [CW-1:0]         limit;
    logic [CW+CNT_W-1:0]   hits_ext;
    logic                  take;
    t_scan_stat            scan_stat;
    logic [CW-1:0]         scan_hits;
    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic [WORD_W-1:0]     rd_data;

    // request decode
    assign o_in_ready = !scan_stat.busy;
    assign in_acc     = i_in_valid && o_in_ready;
    assign idx_ok     = (32'(i_entry_index) < 32'(MAX_MASKS));
    assign idx_ext    = {{AW{1'b0}}, i_entry_index};
    assign ram_we     = in_acc && (i_action == ACT_LOAD) && idx_ok;
    assign start      = in_acc && (i_action == ACT_QUERY);

    // scan length, saturated to the table depth
    assign cnt_ext = {{CW{1'b0}}, r_mask_count};
    assign limit   = (32'(r_mask_count) > 32'(MAX_MASKS)) ? CW'(MAX_MASKS)
                                                          : cnt_ext[CW-1:0];

    // mask table
    smmc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_MASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (idx_ext[AW-1:0]),
        .i_wdata (i_mask_value),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // scan engine
    smmc_scan #(
        .MAX_MASKS (MAX_MASKS)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_diff    (i_first_address ^ i_second_address),
        .i_limit   (limit),
        .i_take    (take),
        .o_stat    (scan_stat),
        .o_hits    (scan_hits),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data)
    );

    // hand the result over when the output register is free
    assign take     = scan_stat.result_valid && (!r_out_valid || i_out_ready);
    assign hits_ext = {{CNT_W{1'b0}}, scan_hits};

    // config register and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_count <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask_count <= i_cfg_wdata;
            end
            if (take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (take) begin
            r_match <= hits_ext[CNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_match_count = r_match;

    // checks
    `SMMC_ASSERT_NEXT(a_zero_limit, i_clk, i_rst_n, start && (limit == '0), scan_stat.result_valid && (scan_hits == '0))
    `SMMC_ASSERT_NEXT(a_load_no_scan, i_clk, i_rst_n, in_acc && (i_action == ACT_LOAD), !scan_stat.busy)
    `SMMC_ASSERT_IMPL(a_no_rw_overlap, i_clk, i_rst_n, ram_we, !rd_en)

endmodule

/* hw/rtl/smmc_ram.sv */
// generic single-write, single-read ram with registered read data
module smmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/smmc_scan.sv */
// scan engine: walks the mask table one entry a cycle and counts matches
module smmc_scan #(
    parameter int MAX_MASKS = 1024,
    localparam int AW = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1,
    localparam int CW = $clog2(MAX_MASKS + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [smmc_pkg::WORD_W-1:0] i_diff,
    input  logic [CW-1:0]              i_limit,
    input  logic                       i_take,
    output smmc_pkg::t_scan_stat       o_stat,
    output logic [CW-1:0]              o_hits,
    output logic                       o_rd_en,
    output logic [AW-1:0]              o_rd_addr,
    input  logic [smmc_pkg::WORD_W-1:0] i_rd_data
);
    import smmc_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_HOLD
    } t_state;

    t_state              r_state, n_state;
    logic                r_pend, n_pend;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_hits, n_hits;
    logic [CW-1:0]       r_limit, n_limit;
    logic [WORD_W-1:0]   r_diff, n_diff;
    logic                rd_en;

    // next-state and accumulate logic
    always_comb begin
        n_state = r_state;
        n_pend  = 1'b0;
        n_idx   = r_idx;
        n_hits  = r_hits;
        n_limit = r_limit;
        n_diff  = r_diff;
        rd_en   = 1'b0;

        // count the entry read in the previous cycle
        if (r_pend && ((r_diff & i_rd_data) == '0)) begin
            n_hits = r_hits + CW'(1);
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_diff  = i_diff;
                    n_limit = i_limit;
                    n_idx   = '0;
                    n_hits  = '0;
                    n_state = (i_limit == '0) ? S_HOLD : S_READ;
                end
            end
            S_READ: begin
                rd_en  = 1'b1;
                n_pend = 1'b1;
                n_idx  = r_idx + CW'(1);
                if (r_idx == (r_limit - CW'(1))) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (!r_pend && i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
        r_idx   <= n_idx;
        r_hits  <= n_hits;
        r_limit <= n_limit;
        r_diff  <= n_diff;
    end

    // status and memory read port
    assign o_stat.busy         = (r_state != S_IDLE);
    assign o_stat.result_valid = (r_state == S_HOLD) && !r_pend;
    assign o_hits              = r_hits;
    assign o_rd_en             = rd_en;
    assign o_rd_addr           = r_idx[AW-1:0];

endmodule

/* bench/tb.sv */
// self-checking testbench for the subnet mask match counter
`timescale 1ns / 1ps

module tb;
    import smmc_pkg::*;

    localparam int MAX_MASKS  = 1024;
    localparam int CYCLE_CAP  = 1000000;
    localparam int IDLE_HEAVY = 81;
    localparam int IDLE_LIGHT = 13;
    localparam int COUNT_CAP  = 64;

    // one request as the sender sees it
    typedef struct packed {
        logic              action;
        logic [IDX_W-1:0]  idx;
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] addr_a;
        logic [WORD_W-1:0] addr_b;
    } t_smmc_req;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              out_ready = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CNT_W-1:0]  cfg_wdata = '0;
    t_smmc_req         cur = '0;
    wire               o_in_ready;
    wire               o_out_valid;
    wire [CNT_W-1:0]   o_match_count;

    // request backlog, predicted counts and the mirrored table
    t_smmc_req         pending[$];
    logic [CNT_W-1:0]  counts_due[$];
    logic [WORD_W-1:0] mask_mirror [0:MAX_MASKS-1];
    bit                loaded [0:MAX_MASKS-1];
    logic [CNT_W-1:0]  count_setting = '0;
    int                send_idle_pct = 0;
    int                stall_pct = 0;
    int                mismatches = 0;
    int                cycles = 0;

    subnet_mask_match_counter #(
        .MAX_MASKS(MAX_MASKS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (o_in_ready),
        .i_action        (cur.action),
        .i_entry_index   (cur.idx),
        .i_mask_value    (cur.mask),
        .i_first_address (cur.addr_a),
        .i_second_address(cur.addr_b),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (out_ready),
        .o_match_count   (o_match_count),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // count of masks under which both addresses share a subnet
    function automatic logic [CNT_W-1:0] count_matches(input logic [WORD_W-1:0] a,
                                                       input logic [WORD_W-1:0] b);
        int                span;
        int                hits;
        logic [WORD_W-1:0] diff;
        span = (count_setting > MAX_MASKS) ? MAX_MASKS : int'(count_setting);
        diff = a ^ b;
        hits = 0;
        for (int k = 0; k < span; k++) begin
            if ((diff & mask_mirror[k]) == '0) hits++;
        end
        return CNT_W'(hits);
    endfunction

    // number of entries loaded contiguously from entry 0
    function automatic int loaded_prefix();
        int p;
        p = 0;
        while (p < MAX_MASKS && loaded[p]) p++;
        return p;
    endfunction

    // mostly prefix-style masks, some arbitrary words
    function automatic logic [WORD_W-1:0] pick_mask();
        int len;
        if ($urandom_range(0, 99) < 30) return $urandom;
        len = $urandom_range(0, 32);
        if (len == 0) return '0;
        return {WORD_W{1'b1}} << (32 - len);
    endfunction

    // driver: present requests, update the mirror or queue the predicted count on acceptance
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) begin
                if (cur.action == ACT_LOAD) begin
                    if (cur.idx < MAX_MASKS) mask_mirror[cur.idx] = cur.mask;
                end else begin
                    counts_due.insert(counts_due.size(),
                                      count_matches(cur.addr_a, cur.addr_b));
                end
            end
            if (!in_valid || o_in_ready) begin
                if (pending.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur      <= pending.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result with the oldest predicted count
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (counts_due.size() == 0) begin
                    $display("%0t: result %0d arrived with none expected", $time,
                             o_match_count);
                    mismatches++;
                end else if (o_match_count !== counts_due[0]) begin
                    $display("%0t: match_count expected %0d got %0d", $time,
                             counts_due[0], o_match_count);
                    mismatches++;
                    void'(counts_due.pop_front());
                end else begin
                    void'(counts_due.pop_front());
                end
            end
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_CAP) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic push_load(input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] mask);
        t_smmc_req r;
        r.action = ACT_LOAD;
        r.idx    = idx;
        r.mask   = mask;
        r.addr_a = $urandom;
        r.addr_b = $urandom;
        loaded[idx] = 1'b1;
        pending.insert(pending.size(), r);
    endtask

    task automatic push_query(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
        t_smmc_req r;
        r.action = ACT_QUERY;
        r.idx    = IDX_W'($urandom);
        r.mask   = $urandom;
        r.addr_a = a;
        r.addr_b = b;
        pending.insert(pending.size(), r);
    endtask

    // wait until every request is taken and every result is in
    task automatic wait_drained();
        while (pending.size() > 0 || in_valid || counts_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_mask_count(input logic [CNT_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        count_setting = v;
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        stall_pct     = recv_pct;
    endtask

    // random mix of loads and queries
    task automatic queue_random(input int n);
        int                pfx;
        int                sel;
        int                idx;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 99) < 40) begin
                pfx = loaded_prefix();
                sel = $urandom_range(0, 99);
                if (sel < 40) idx = pfx;
                else if (sel < 70) idx = $urandom_range(0, pfx + 8);
                else idx = $urandom_range(0, MAX_MASKS - 1);
                if (idx > MAX_MASKS - 1) idx = MAX_MASKS - 1;
                push_load(IDX_W'(idx), pick_mask());
            end else begin
                a   = $urandom;
                sel = $urandom_range(0, 99);
                if (sel < 25) b = a;
                else if (sel < 75) b = a ^ ($urandom >> $urandom_range(0, 31));
                else b = $urandom;
                push_query(a, b);
            end
        end
    endtask

    // stimulus sequence
    initial begin
        int hi;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // zero count after reset, then a handful of known masks
        set_idling(0, 0);
        push_query('0, 32'hFFFF_FFFF);
        push_load(0, 32'h0000_0000);
        push_load(1, 32'hFFFF_FFFF);
        push_load(2, 32'hFFFF_FF00);
        push_load(3, 32'hFFFF_0000);
        push_load(4, 32'hFF00_0000);
        push_load(5, 32'h8000_0000);
        push_load(6, 32'h0000_0001);
        push_load(7, 32'hFFFF_FFFE);
        push_load(1023, 32'hFFFF_FFFF);
        wait_drained();

        // queries against the known masks
        set_mask_count(8);
        push_query('0, '0);
        push_query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_query('0, 32'hFFFF_FFFF);
        push_query(32'hC0A8_0101, 32'hC0A8_01FE);
        push_query(32'hC0A8_0101, 32'hC0A8_0201);
        push_query(32'h0A00_0001, 32'h0A01_0001);
        push_query('0, 32'h0000_0001);
        push_query(32'h7FFF_FFFF, 32'h8000_0000);
        push_query(32'h1234_5678, 32'h1234_5679);
        push_query(32'h8000_0000, 32'h8000_0001);
        wait_drained();

        // random phases, each idling pattern with a few count settings
        for (int m = 0; m < 4; m++) begin
            unique case (m)
                0: begin
                    set_idling(0, 0);
                end
                1: begin
                    set_idling(IDLE_HEAVY, 0);
                end
                2: begin
                    set_idling(0, IDLE_HEAVY);
                end
                default: begin
                    set_idling(IDLE_LIGHT, IDLE_LIGHT);
                end
            endcase
            for (int s = 0; s < 3; s++) begin
                hi = loaded_prefix();
                if (hi > COUNT_CAP) hi = COUNT_CAP;
                set_mask_count((s == 0) ? CNT_W'(hi) : CNT_W'($urandom_range(0, hi)));
                queue_random(48);
                wait_drained();
            end
        end

        // quiet period to catch stray results
        repeat (64) @(posedge i_clk);
        if (mismatches == 0 && counts_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
